/* hdl/kt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kt_pkg
// Shared constants and the token type that travels along the cell chain of
// the Kendall tau distance block.
// ----------------------------------------------------------------------------
package kt_pkg;

    // largest permutation size handled
    localparam int MAX_SIZE    = 32;

    // fixed field widths of the beat payloads
    localparam int VAL_W       = 6;
    localparam int DIST_OUT_W  = 9;
    localparam int COUNT_OUT_W = 6;

    // derived widths
    localparam int POS_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
    localparam int CMP_W    = (SIZE_W > VAL_W) ? SIZE_W : VAL_W;
    localparam int LAST_POS = MAX_SIZE - 1;
    localparam int DIST_MAX = MAX_SIZE * (MAX_SIZE - 1) / 2;
    localparam int DIST_W   = $clog2(DIST_MAX + 1);

    typedef enum logic {
        OP_REFERENCE = 1'b0,
        OP_CANDIDATE = 1'b1
    } kt_op_t;

    // one candidate element in flight through the chain
    typedef struct packed {
        logic             valid;   // candidate element present
        logic             hit;     // value maps to a reference position
        logic             last;    // final element of the candidate
        logic [POS_W-1:0] pos;     // reference position of the value
        logic [POS_W-1:0] add;     // seen positions above pos, so far
    } kt_tok_t;

endpackage
`default_nettype wire

/* hdl/kendall_tau_distance.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kendall_tau_distance
// Kendall tau distance between a stored reference permutation and a streamed
// candidate permutation.
// ----------------------------------------------------------------------------
// Reference beats (operation 0) fill a position table; their last flag sets
// the size in use. Candidate beats (operation 1) look up their reference
// position and enter a row of MAX_SIZE cells, one per reference position,
// each holding one bit of the seen bitmap. A candidate element moves one cell
// per cycle, counting the seen positions above its own, so one beat is taken
// every cycle and a candidate's elements follow each other through the row.
// The result beat of a candidate is registered once its last element has
// passed all MAX_SIZE cells of the row. While a result beat waits at the
// output, the row and the input hold.
// ----------------------------------------------------------------------------
module kendall_tau_distance
    import kt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_operation,
    input  wire logic [VAL_W-1:0]       s_value,
    input  wire logic                   s_last,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [DIST_OUT_W-1:0]       m_distance,
    output logic [COUNT_OUT_W-1:0]      m_element_count
);

    kt_tok_t tok [MAX_SIZE + 1];
    logic    advance;

    assign s_ready = advance;

    kt_pos_table u_pos_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_valid && advance),
        .operation (s_operation),
        .value     (s_value),
        .last      (s_last),
        .tok       (tok[0])
    );

    for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
        kt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_idx (POS_W'(i)),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    kt_tally u_tally (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tok             (tok[MAX_SIZE]),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_distance      (m_distance),
        .m_element_count (m_element_count)
    );

    // a held result freezes the end of the chain
    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(tok[MAX_SIZE]))
        else $error("chain moved while result beat stalled");

    // every result covers at least one candidate element
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_element_count != '0))
        else $error("result beat with zero element count");

    // a new result only comes from a last candidate element leaving the chain
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(m_valid) && m_valid) |-> $past(tok[MAX_SIZE].valid && tok[MAX_SIZE].last))
        else $error("result beat without a closing element");

endmodule
`default_nettype wire

/* hdl/kt_pos_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kt_pos_table
// Reference position table. Reference beats record each value's position;
// candidate beats look their value up and leave as a token for the chain.
// ----------------------------------------------------------------------------
module kt_pos_table
    import kt_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic             operation,
    input  wire logic [VAL_W-1:0] value,
    input  wire logic             last,
    output kt_tok_t               tok
);

    logic [POS_W-1:0]  pos_mem [MAX_SIZE];
    logic [POS_W-1:0]  load_index_reg, load_index_next;
    logic [SIZE_W-1:0] ref_size_reg, ref_size_next;

    logic [POS_W-1:0] idx;
    logic             in_table;
    logic             in_ref;
    logic             ref_beat;

    assign idx      = POS_W'(value - VAL_W'(1));
    assign in_table = (value != '0) && (CMP_W'(value) <= CMP_W'(MAX_SIZE));
    assign in_ref   = in_table && (CMP_W'(value) <= CMP_W'(ref_size_reg));
    assign ref_beat = accept && (kt_op_t'(operation) == OP_REFERENCE);

    always_comb begin
        load_index_next = load_index_reg;
        ref_size_next   = ref_size_reg;
        if (ref_beat) begin
            if (last) begin
                ref_size_next   = SIZE_W'(load_index_reg) + SIZE_W'(1);
                load_index_next = '0;
            end else if (load_index_reg == POS_W'(LAST_POS)) begin
                load_index_next = '0;
            end else begin
                load_index_next = load_index_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_index_reg <= '0;
            ref_size_reg   <= '0;
        end else begin
            load_index_reg <= load_index_next;
            ref_size_reg   <= ref_size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ref_beat && in_table) begin
            pos_mem[idx] <= load_index_reg;
        end
    end

    always_comb begin
        tok.valid = accept && (kt_op_t'(operation) == OP_CANDIDATE);
        tok.hit   = in_ref;
        tok.last  = last;
        // a value with no reference position carries a zero position
        tok.pos   = in_ref ? pos_mem[idx] : '0;
        tok.add   = '0;
    end

endmodule
`default_nettype wire

/* hdl/kt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kt_cell
// One reference position of the seen bitmap. A passing token counts this
// position if it is seen and above the token's own, then marks or clears it.
// ----------------------------------------------------------------------------
module kt_cell
    import kt_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic [POS_W-1:0] cell_idx,
    input  kt_tok_t               tok_in,
    output kt_tok_t               tok_out
);

    kt_tok_t tok_reg, tok_next;
    logic    seen_reg, seen_next;

    always_comb begin
        tok_next  = tok_in;
        seen_next = seen_reg;
        if (tok_in.valid && tok_in.hit && seen_reg && (cell_idx > tok_in.pos)) begin
            tok_next.add = tok_in.add + POS_W'(1);
        end
        if (tok_in.valid) begin
            // the last element closes the candidate, so the bitmap starts over
            if (tok_in.last) begin
                seen_next = 1'b0;
            end else if (tok_in.hit && (tok_in.pos == cell_idx)) begin
                seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= '0;
            seen_reg <= 1'b0;
        end else if (advance) begin
            tok_reg  <= tok_next;
            seen_reg <= seen_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

/* hdl/kt_tally.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kt_tally
// End of the chain: sums the per-element counts with saturation, counts the
// candidate elements and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module kt_tally
    import kt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  kt_tok_t                     tok,
    output logic                        advance,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [DIST_OUT_W-1:0]       m_distance,
    output logic [COUNT_OUT_W-1:0]      m_element_count
);

    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [SIZE_W-1:0]      count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DIST_OUT_W-1:0]  m_dist_reg, m_dist_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;
    logic [DIST_W:0]        sum;
    logic [DIST_W-1:0]      dist_sat;
    logic [SIZE_W-1:0]      count_inc;
    logic                   emit;

    // the whole chain holds while a finished result waits
    assign advance = !m_valid_reg || m_ready;
    assign emit    = advance && tok.valid && tok.last;

    always_comb begin
        sum       = (DIST_W + 1)'(dist_reg) + (DIST_W + 1)'(tok.add);
        dist_sat  = (sum > (DIST_W + 1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(sum);
        count_inc = (count_reg == SIZE_W'(MAX_SIZE)) ? count_reg : count_reg + SIZE_W'(1);

        dist_next    = dist_reg;
        count_next   = count_reg;
        m_dist_next  = m_dist_reg;
        m_count_next = m_count_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        if (advance && tok.valid) begin
            if (tok.last) begin
                m_valid_next = 1'b1;
                m_dist_next  = DIST_OUT_W'(dist_sat);
                m_count_next = COUNT_OUT_W'(count_inc);
                dist_next    = '0;
                count_next   = '0;
            end else begin
                dist_next  = dist_sat;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            dist_reg    <= dist_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_dist_reg  <= m_dist_next;
            m_count_reg <= m_count_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_distance      = m_dist_reg;
    assign m_element_count = m_count_reg;

endmodule
`default_nettype wire
